// File: hw/rtl/rtc_pkg.sv
package rtc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VTX_W      = 32;
    localparam int E_W        = VTX_W + 1;          // edge / offset vectors
    localparam int D_W        = 18;                 // ray direction
    localparam int TOL_W      = 17;
    localparam int T_W        = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int VAL_W      = 56;                 // h, q, det, un, vn
    localparam int B_W        = E_W + 1;            // multiplier b operand
    localparam int DIG_W      = 18;                 // multiplier digit
    localparam int ACC_W      = 96;                 // dot product accumulator
    localparam int UOP_IDX_W  = 5;
    localparam int DIV_CNT_W  = $clog2(T_W);

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    localparam int DIR_X_RESET = 65536;
    localparam int TOL_RESET   = 1311;

    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = CFG_IDX_W'(6);

    localparam logic [UOP_IDX_W-1:0] UOP_DET_END = UOP_IDX_W'(14);
    localparam logic [UOP_IDX_W-1:0] UOP_TN_END  = UOP_IDX_W'(23);
    localparam logic [UOP_IDX_W-1:0] UOP_TOL     = UOP_IDX_W'(24);

    typedef enum logic [3:0] {
        A_E1X, A_E1Y, A_E1Z, A_E2X, A_E2Y, A_E2Z,
        A_HX, A_HY, A_HZ, A_QX, A_QY, A_QZ, A_DET
    } a_sel_t;

    typedef enum logic [3:0] {
        B_DX, B_DY, B_DZ, B_E1X, B_E1Y, B_E1Z,
        B_SX, B_SY, B_SZ, B_E2X, B_E2Y, B_E2Z, B_TOL
    } b_sel_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_HX, DST_HY, DST_HZ, DST_QX, DST_QY, DST_QZ,
        DST_DET, DST_UN, DST_VN, DST_TN, DST_TOLD
    } dest_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   sub;
        logic   first;
        logic   last;
        logic   two_digit;
        dest_t  dest;
    } uop_t;

    typedef struct packed {
        logic step;
        logic digit;
        logic acc_en;
        logic first;
        logic sub;
    } mac_cmd_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic digit;
        logic acc_step;
        logic norm;
        logic div_init;
        logic div_step;
        logic hit_upd;
        logic emit;
        uop_t uop;
    } rtc_cmd_t;

    typedef struct packed {
        logic det_degen;
        logic bary_reject;
        logic tn_nonpos;
        logic div_sat;
        logic last;
    } rtc_stat_t;

    // one product term per entry; dests other than TN/TOLD take the floored QF value
    function automatic uop_t uop_rom(input logic [UOP_IDX_W-1:0] idx);
        uop_t u;
        u = '{A_E1X, B_DX, 1'b0, 1'b1, 1'b1, 1'b0, DST_NONE};
        case (idx)
            5'd0:    u = '{A_E2Z, B_DY, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE};
            5'd1:    u = '{A_E2Y, B_DZ, 1'b1, 1'b0, 1'b1, 1'b0, DST_HX};
            5'd2:    u = '{A_E2X, B_DZ, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE};
            5'd3:    u = '{A_E2Z, B_DX, 1'b1, 1'b0, 1'b1, 1'b0, DST_HY};
            5'd4:    u = '{A_E2Y, B_DX, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE};
            5'd5:    u = '{A_E2X, B_DY, 1'b1, 1'b0, 1'b1, 1'b0, DST_HZ};
            5'd6:    u = '{A_E1Z, B_SY, 1'b0, 1'b1, 1'b0, 1'b1, DST_NONE};
            5'd7:    u = '{A_E1Y, B_SZ, 1'b1, 1'b0, 1'b1, 1'b1, DST_QX};
            5'd8:    u = '{A_E1X, B_SZ, 1'b0, 1'b1, 1'b0, 1'b1, DST_NONE};
            5'd9:    u = '{A_E1Z, B_SX, 1'b1, 1'b0, 1'b1, 1'b1, DST_QY};
            5'd10:   u = '{A_E1Y, B_SX, 1'b0, 1'b1, 1'b0, 1'b1, DST_NONE};
            5'd11:   u = '{A_E1X, B_SY, 1'b1, 1'b0, 1'b1, 1'b1, DST_QZ};
            5'd12:   u = '{A_HX, B_E1X, 1'b0, 1'b1, 1'b0, 1'b1, DST_NONE};
            5'd13:   u = '{A_HY, B_E1Y, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE};
            5'd14:   u = '{A_HZ, B_E1Z, 1'b0, 1'b0, 1'b1, 1'b1, DST_DET};
            5'd15:   u = '{A_HX, B_SX, 1'b0, 1'b1, 1'b0, 1'b1, DST_NONE};
            5'd16:   u = '{A_HY, B_SY, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE};
            5'd17:   u = '{A_HZ, B_SZ, 1'b0, 1'b0, 1'b1, 1'b1, DST_UN};
            5'd18:   u = '{A_QX, B_DX, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE};
            5'd19:   u = '{A_QY, B_DY, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE};
            5'd20:   u = '{A_QZ, B_DZ, 1'b0, 1'b0, 1'b1, 1'b0, DST_VN};
            5'd21:   u = '{A_QX, B_E2X, 1'b0, 1'b1, 1'b0, 1'b1, DST_NONE};
            5'd22:   u = '{A_QY, B_E2Y, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE};
            5'd23:   u = '{A_QZ, B_E2Z, 1'b0, 1'b0, 1'b1, 1'b1, DST_TN};
            5'd24:   u = '{A_DET, B_TOL, 1'b0, 1'b1, 1'b1, 1'b0, DST_TOLD};
            default: u = '{A_E1X, B_DX, 1'b0, 1'b1, 1'b1, 1'b0, DST_NONE};
        endcase
        return u;
    endfunction

endpackage

// File: hw/rtl/rtc_mac.sv
module rtc_mac
    import rtc_pkg::*;
(
    input  logic                    clk,
    input  mac_cmd_t                cmd,
    input  logic signed [VAL_W-1:0] a,
    input  logic signed [B_W-1:0]   b,
    output logic signed [ACC_W-1:0] acc_next
);

    localparam int UB_W  = 2 * DIG_W;
    localparam int PP_W  = VAL_W + DIG_W;
    localparam int MAG_W = VAL_W + UB_W;

    logic [VAL_W-1:0]        ua;
    logic [B_W-1:0]          b_abs;
    logic [UB_W-1:0]         ub;
    logic [DIG_W-1:0]        dig;
    logic [PP_W-1:0]         pp;
    logic [MAG_W-1:0]        mag_reg;
    logic [MAG_W-1:0]        mag_next;
    logic                    neg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] mag_ext;
    logic signed [ACC_W-1:0] base;

    // sign-magnitude: |a| times one 18-bit digit of |b| per cycle while cmd.step is high
    assign ua    = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
    assign b_abs = b[B_W-1] ? B_W'(-b) : B_W'(b);
    assign ub    = UB_W'(b_abs);
    assign dig   = cmd.digit ? ub[UB_W-1:DIG_W] : ub[DIG_W-1:0];
    assign pp    = PP_W'(ua) * PP_W'(dig);

    assign mag_next = cmd.digit ? mag_reg + (MAG_W'(pp) << DIG_W) : MAG_W'(pp);

    assign mag_ext  = ACC_W'(mag_reg);
    assign base     = cmd.first ? '0 : acc_reg;
    assign acc_next = base + (neg_reg ? -mag_ext : mag_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            mag_reg <= mag_next;
            if (!cmd.digit)
            begin
                neg_reg <= a[VAL_W-1] ^ b[B_W-1] ^ cmd.sub;
            end
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// File: hw/rtl/rtc_dp.sv
module rtc_dp
    import rtc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [VTX_W-1:0] a_x,
    input  logic signed [VTX_W-1:0] a_y,
    input  logic signed [VTX_W-1:0] a_z,
    input  logic signed [VTX_W-1:0] b_x,
    input  logic signed [VTX_W-1:0] b_y,
    input  logic signed [VTX_W-1:0] b_z,
    input  logic signed [VTX_W-1:0] c_x,
    input  logic signed [VTX_W-1:0] c_y,
    input  logic signed [VTX_W-1:0] c_z,
    input  logic                   last_triangle,
    input  rtc_cmd_t               cmd,
    output rtc_stat_t              stat,
    output logic                   hit,
    output logic [T_W-1:0]         closest_t
);

    logic signed [VTX_W-1:0] org_reg [3];
    logic signed [D_W-1:0]   dir_reg [3];
    logic [TOL_W-1:0]        tol_reg;

    logic signed [E_W-1:0]   e1_reg [3];
    logic signed [E_W-1:0]   e2_reg [3];
    logic signed [E_W-1:0]   s_reg  [3];
    logic signed [VAL_W-1:0] h_reg  [3];
    logic signed [VAL_W-1:0] q_reg  [3];
    logic signed [VAL_W-1:0] det_reg;
    logic signed [VAL_W-1:0] un_reg;
    logic signed [VAL_W-1:0] vn_reg;
    logic signed [ACC_W-1:0] tn_reg;
    logic signed [ACC_W-1:0] told_reg;
    logic                    last_reg;

    logic [VAL_W-1:0]        rem_reg;
    logic [T_W-1:0]          num_lo_reg;
    logic [T_W-1:0]          quo_reg;
    logic [T_W-1:0]          best_t_reg;
    logic                    any_hit_reg;
    logic                    hit_reg;
    logic [T_W-1:0]          closest_t_reg;

    logic signed [VAL_W-1:0] a_op;
    logic signed [B_W-1:0]   b_op;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [VAL_W-1:0] acc_q;
    mac_cmd_t                mac_cmd;

    logic signed [ACC_W-1:0] det_w;
    logic signed [ACC_W-1:0] un_w;
    logic signed [ACC_W-1:0] vn_w;
    logic signed [ACC_W-1:0] lhs_u;
    logic signed [ACC_W-1:0] lhs_v;
    logic signed [ACC_W-1:0] lhs_uv;
    logic signed [ACC_W-1:0] lo_b;
    logic signed [ACC_W-1:0] hi_b;
    logic [VAL_W-1:0]        rem2;
    logic                    ge;

    always_comb
    begin
        case (cmd.uop.a_sel)
            A_E1X:   a_op = VAL_W'(e1_reg[0]);
            A_E1Y:   a_op = VAL_W'(e1_reg[1]);
            A_E1Z:   a_op = VAL_W'(e1_reg[2]);
            A_E2X:   a_op = VAL_W'(e2_reg[0]);
            A_E2Y:   a_op = VAL_W'(e2_reg[1]);
            A_E2Z:   a_op = VAL_W'(e2_reg[2]);
            A_HX:    a_op = h_reg[0];
            A_HY:    a_op = h_reg[1];
            A_HZ:    a_op = h_reg[2];
            A_QX:    a_op = q_reg[0];
            A_QY:    a_op = q_reg[1];
            A_QZ:    a_op = q_reg[2];
            A_DET:   a_op = det_reg;
            default: a_op = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.uop.b_sel)
            B_DX:    b_op = B_W'(dir_reg[0]);
            B_DY:    b_op = B_W'(dir_reg[1]);
            B_DZ:    b_op = B_W'(dir_reg[2]);
            B_E1X:   b_op = B_W'(e1_reg[0]);
            B_E1Y:   b_op = B_W'(e1_reg[1]);
            B_E1Z:   b_op = B_W'(e1_reg[2]);
            B_SX:    b_op = B_W'(s_reg[0]);
            B_SY:    b_op = B_W'(s_reg[1]);
            B_SZ:    b_op = B_W'(s_reg[2]);
            B_E2X:   b_op = B_W'(e2_reg[0]);
            B_E2Y:   b_op = B_W'(e2_reg[1]);
            B_E2Z:   b_op = B_W'(e2_reg[2]);
            B_TOL:   b_op = B_W'({1'b0, tol_reg});
            default: b_op = '0;
        endcase
    end

    assign mac_cmd = '{step:   cmd.mul_step,
                       digit:  cmd.digit,
                       acc_en: cmd.acc_step,
                       first:  cmd.uop.first,
                       sub:    cmd.uop.sub};

    rtc_mac u_mac
    (
        .clk      (clk),
        .cmd      (mac_cmd),
        .a        (a_op),
        .b        (b_op),
        .acc_next (acc_next)
    );

    // floor back to QF
    assign acc_q = VAL_W'(acc_next >>> FRAC_BITS);

    // barycentric window, all scaled by det (det already made positive)
    assign det_w  = ACC_W'(det_reg);
    assign un_w   = ACC_W'(un_reg);
    assign vn_w   = ACC_W'(vn_reg);
    assign lhs_u  = un_w <<< FRAC_BITS;
    assign lhs_v  = vn_w <<< FRAC_BITS;
    assign lhs_uv = (un_w + vn_w) <<< FRAC_BITS;
    assign lo_b   = -told_reg;
    assign hi_b   = (det_w <<< FRAC_BITS) + told_reg;

    assign stat.det_degen   = (det_reg == '0) || (det_reg == '1);
    assign stat.bary_reject = (lhs_u < lo_b) || (lhs_u > hi_b) || (lhs_v < lo_b)
                              || (lhs_uv > hi_b);
    assign stat.tn_nonpos   = tn_reg[ACC_W-1] || (tn_reg == '0);
    assign stat.div_sat     = (tn_reg >= (det_w <<< T_W));
    assign stat.last        = last_reg;

    assign rem2 = {rem_reg[VAL_W-2:0], num_lo_reg[T_W-1]};
    assign ge   = (rem2 >= VAL_W'(det_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]  <= '0;
            org_reg[1]  <= '0;
            org_reg[2]  <= '0;
            dir_reg[0]  <= D_W'(DIR_X_RESET);
            dir_reg[1]  <= '0;
            dir_reg[2]  <= '0;
            tol_reg     <= TOL_W'(TOL_RESET);
            best_t_reg  <= T_MAX;
            any_hit_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ORG_X: org_reg[0] <= cfg_data[VTX_W-1:0];
                    CFG_ORG_Y: org_reg[1] <= cfg_data[VTX_W-1:0];
                    CFG_ORG_Z: org_reg[2] <= cfg_data[VTX_W-1:0];
                    CFG_DIR_X: dir_reg[0] <= cfg_data[D_W-1:0];
                    CFG_DIR_Y: dir_reg[1] <= cfg_data[D_W-1:0];
                    CFG_DIR_Z: dir_reg[2] <= cfg_data[D_W-1:0];
                    CFG_TOL:   tol_reg    <= cfg_data[TOL_W-1:0];
                    default:   ;
                endcase
            end
            // equal t keeps the earlier hit
            if (cmd.hit_upd && (quo_reg != '0))
            begin
                if (quo_reg < best_t_reg)
                begin
                    best_t_reg <= quo_reg;
                end
                any_hit_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                best_t_reg  <= T_MAX;
                any_hit_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e1_reg[0] <= E_W'(b_x) - E_W'(a_x);
            e1_reg[1] <= E_W'(b_y) - E_W'(a_y);
            e1_reg[2] <= E_W'(b_z) - E_W'(a_z);
            e2_reg[0] <= E_W'(c_x) - E_W'(a_x);
            e2_reg[1] <= E_W'(c_y) - E_W'(a_y);
            e2_reg[2] <= E_W'(c_z) - E_W'(a_z);
            s_reg[0]  <= E_W'(org_reg[0]) - E_W'(a_x);
            s_reg[1]  <= E_W'(org_reg[1]) - E_W'(a_y);
            s_reg[2]  <= E_W'(org_reg[2]) - E_W'(a_z);
            last_reg  <= last_triangle;
        end

        if (cmd.acc_step && cmd.uop.last)
        begin
            case (cmd.uop.dest)
                DST_HX:   h_reg[0] <= acc_q;
                DST_HY:   h_reg[1] <= acc_q;
                DST_HZ:   h_reg[2] <= acc_q;
                DST_QX:   q_reg[0] <= acc_q;
                DST_QY:   q_reg[1] <= acc_q;
                DST_QZ:   q_reg[2] <= acc_q;
                DST_DET:  det_reg  <= acc_q;
                DST_UN:   un_reg   <= acc_q;
                DST_VN:   vn_reg   <= acc_q;
                DST_TN:   tn_reg   <= acc_next;
                DST_TOLD: told_reg <= acc_next;
                default:  ;
            endcase
        end

        if (cmd.norm && det_reg[VAL_W-1])
        begin
            det_reg <= -det_reg;
            un_reg  <= -un_reg;
            vn_reg  <= -vn_reg;
            tn_reg  <= -tn_reg;
        end

        // when tn < det * 2^31 the top part is already below det; otherwise quo saturates to T_MAX
        if (cmd.div_init)
        begin
            rem_reg    <= VAL_W'(tn_reg >>> T_W);
            num_lo_reg <= tn_reg[T_W-1:0];
            quo_reg    <= stat.div_sat ? T_MAX : '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg    <= ge ? rem2 - VAL_W'(det_reg) : rem2;
            num_lo_reg <= {num_lo_reg[T_W-2:0], 1'b0};
            quo_reg    <= {quo_reg[T_W-2:0], ge};
        end

        if (cmd.emit)
        begin
            hit_reg       <= any_hit_reg;
            closest_t_reg <= best_t_reg;
        end
    end

    assign hit       = hit_reg;
    assign closest_t = closest_t_reg;

endmodule

// File: hw/rtl/rtc_ctrl.sv
module rtc_ctrl
    import rtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  rtc_stat_t stat,
    output rtc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_D0, S_D1, S_ACC, S_CHK_DET, S_NORM, S_BARY,
        S_DIV_INIT, S_DIV, S_UPDATE, S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [UOP_IDX_W-1:0]   uop_idx_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic                   cand_reg;
    logic                   out_valid_reg;
    uop_t                   uop;
    logic                   out_free;

    assign uop      = uop_rom(uop_idx_reg);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd     = '0;
        cmd.uop = uop;
        case (state_reg)
            S_IDLE:     cmd.load     = in_valid;
            S_D0:       cmd.mul_step = 1'b1;
            S_D1:
            begin
                cmd.mul_step = 1'b1;
                cmd.digit    = 1'b1;
            end
            S_ACC:      cmd.acc_step = 1'b1;
            S_NORM:     cmd.norm     = 1'b1;
            S_DIV_INIT: cmd.div_init = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_UPDATE:   cmd.hit_upd  = cand_reg;
            S_EMIT:     cmd.emit     = out_free;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            uop_idx_reg   <= '0;
            div_cnt_reg   <= '0;
            cand_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg   <= S_D0;
                        uop_idx_reg <= '0;
                        cand_reg    <= 1'b0;
                    end
                end
                S_D0:
                begin
                    state_reg <= uop.two_digit ? S_D1 : S_ACC;
                end
                S_D1:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (uop_idx_reg == UOP_DET_END)
                    begin
                        state_reg <= S_CHK_DET;
                    end
                    else if (uop_idx_reg == UOP_TN_END)
                    begin
                        state_reg <= S_NORM;
                    end
                    else if (uop_idx_reg == UOP_TOL)
                    begin
                        state_reg <= S_BARY;
                    end
                    else
                    begin
                        uop_idx_reg <= uop_idx_reg + 1'b1;
                        state_reg   <= S_D0;
                    end
                end
                S_CHK_DET:
                begin
                    if (stat.det_degen)
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        uop_idx_reg <= uop_idx_reg + 1'b1;
                        state_reg   <= S_D0;
                    end
                end
                S_NORM:
                begin
                    uop_idx_reg <= UOP_TOL;
                    state_reg   <= S_D0;
                end
                S_BARY:
                begin
                    if (stat.bary_reject || stat.tn_nonpos)
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT:
                begin
                    cand_reg    <= 1'b1;
                    div_cnt_reg <= '0;
                    state_reg   <= stat.div_sat ? S_UPDATE : S_DIV;
                end
                S_DIV:
                begin
                    if (div_cnt_reg == DIV_CNT_W'(T_W - 1))
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= stat.last ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/ray_triangle_closest_hit.sv
// Ray / triangle-mesh closest hit, one triangle per item.
// Each item runs up to 25 product terms on one shared 56x18 multiply-accumulate unit
// (a degenerate determinant stops after the det terms), then for a candidate hit a
// 31-step restoring divider for t; in_stall holds off new items until the block is idle.
// The result is registered after the last item, later while an earlier one is held.
// Reset: async active low; clears control state, best hit and config to defaults.
module ray_triangle_closest_hit
    import rtc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VTX_W-1:0] a_x,
    input  logic signed [VTX_W-1:0] a_y,
    input  logic signed [VTX_W-1:0] a_z,
    input  logic signed [VTX_W-1:0] b_x,
    input  logic signed [VTX_W-1:0] b_y,
    input  logic signed [VTX_W-1:0] b_z,
    input  logic signed [VTX_W-1:0] c_x,
    input  logic signed [VTX_W-1:0] c_y,
    input  logic signed [VTX_W-1:0] c_z,
    input  logic                    last_triangle,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    hit,
    output logic [T_W-1:0]          closest_t
);

    rtc_cmd_t  cmd;
    rtc_stat_t stat;

    rtc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rtc_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .a_x           (a_x),
        .a_y           (a_y),
        .a_z           (a_z),
        .b_x           (b_x),
        .b_y           (b_y),
        .b_z           (b_z),
        .c_x           (c_x),
        .c_y           (c_y),
        .c_z           (c_z),
        .last_triangle (last_triangle),
        .cmd           (cmd),
        .stat          (stat),
        .hit           (hit),
        .closest_t     (closest_t)
    );

`ifndef SYNTHESIS
    // an accepted item always takes the engine out of idle, so in_stall is raised behind it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while engine still free");

    a_miss_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (closest_t == T_MAX))
        else $error("no hit but closest_t not saturated");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (closest_t != '0))
        else $error("hit reported with zero distance");
`endif

endmodule

// File: verif/tb_ray_triangle_closest_hit.sv
module tb_ray_triangle_closest_hit;
    import rtc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic                  last;
        logic [8:0][VTX_W-1:0] v;     // ax ay az bx by bz cx cy cz
    } tri_item_t;

    typedef struct packed {
        logic           hit;
        logic [T_W-1:0] t;
    } mesh_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [VTX_W-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [VTX_W-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [VTX_W-1:0] c_x = '0, c_y = '0, c_z = '0;
    logic last_triangle = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [T_W-1:0] closest_t;

    ray_triangle_closest_hit DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mirrored registers and mesh state
    logic [31:0] org [3];
    logic [D_W-1:0] dir [3];
    logic [TOL_W-1:0] tol;
    logic [T_W-1:0] best_t;
    logic any_hit;

    tri_item_t pending_tris[$];
    mesh_result_t expected_results[$];
    tri_item_t cur_tri;
    int gap_left = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;
    int errors = 0;
    int tris_sent = 0;
    int meshes_seen = 0;
    int hits_seen = 0;

    function automatic wide_t clamp61(wide_t x);
        wide_t lim;
        lim = wide_t'(1) <<< 61;
        if (x < -lim)
            return -lim;
        if (x > lim)
            return lim;
        return x;
    endfunction

    // Moller-Trumbore test in wide arithmetic, floored to QF like the datapath; returns 1 on a hit
    function automatic bit triangle_distance(tri_item_t tr, output logic [T_W-1:0] t_out);
        wide_t e1 [3], e2 [3], s [3], d [3], h [3], q [3];
        wide_t det, un, vn, tn, one, tl, lo_b, hi_b, quo;
        one = wide_t'(1) <<< FRAC_BITS;
        tl = wide_t'({1'b0, tol});
        t_out = '0;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = wide_t'($signed(tr.v[3+i])) - wide_t'($signed(tr.v[i]));
            e2[i] = wide_t'($signed(tr.v[6+i])) - wide_t'($signed(tr.v[i]));
            s[i] = wide_t'($signed(org[i])) - wide_t'($signed(tr.v[i]));
            d[i] = wide_t'($signed(dir[i]));
        end
        h[0] = (d[1] * e2[2] - d[2] * e2[1]) >>> FRAC_BITS;
        h[1] = (d[2] * e2[0] - d[0] * e2[2]) >>> FRAC_BITS;
        h[2] = (d[0] * e2[1] - d[1] * e2[0]) >>> FRAC_BITS;
        q[0] = clamp61((s[1] * e1[2] - s[2] * e1[1]) >>> FRAC_BITS);
        q[1] = clamp61((s[2] * e1[0] - s[0] * e1[2]) >>> FRAC_BITS);
        q[2] = clamp61((s[0] * e1[1] - s[1] * e1[0]) >>> FRAC_BITS);
        det = clamp61((e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2]) >>> FRAC_BITS);
        if (det == 0 || det == -1)
            return 1'b0;
        un = clamp61((s[0] * h[0] + s[1] * h[1] + s[2] * h[2]) >>> FRAC_BITS);
        vn = clamp61((d[0] * q[0] + d[1] * q[1] + d[2] * q[2]) >>> FRAC_BITS);
        tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (det < 0)
        begin
            det = -det;
            un = -un;
            vn = -vn;
            tn = -tn;
        end
        lo_b = -tl * det;
        hi_b = (one + tl) * det;
        if (un * one < lo_b || un * one > hi_b)
            return 1'b0;
        if (vn * one < lo_b || (un + vn) * one > hi_b)
            return 1'b0;
        if (tn <= 0)
            return 1'b0;
        quo = tn / det;
        if (quo >= (wide_t'(1) <<< T_W))
            t_out = T_MAX;
        else
            t_out = quo[T_W-1:0];
        return t_out != '0;
    endfunction

    function automatic void mesh_accumulate(tri_item_t tr);
        logic [T_W-1:0] t;
        if (triangle_distance(tr, t))
        begin
            if (!any_hit || t < best_t)
                best_t = t;
            any_hit = 1'b1;
        end
        if (tr.last)
        begin
            expected_results.push_back('{any_hit, best_t});
            best_t = T_MAX;
            any_hit = 1'b0;
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_length();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic next_valid;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                mesh_accumulate(cur_tri);
                tris_sent++;
                next_valid = 1'b0;
                gap_left = idle_length();
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_tris.size() > 0)
                begin
                    cur_tri = pending_tris.pop_front();
                    next_valid = 1'b1;
                    a_x <= cur_tri.v[0];
                    a_y <= cur_tri.v[1];
                    a_z <= cur_tri.v[2];
                    b_x <= cur_tri.v[3];
                    b_y <= cur_tri.v[4];
                    b_z <= cur_tri.v[5];
                    c_x <= cur_tri.v[6];
                    c_y <= cur_tri.v[7];
                    c_z <= cur_tri.v[8];
                    last_triangle <= cur_tri.last;
                end
            end
            in_valid <= next_valid;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        mesh_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                meshes_seen++;
                if (hit)
                    hits_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: hit=%0d t=%h", hit, closest_t);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (hit !== exp_r.hit || closest_t !== exp_r.t)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: hit exp %0d got %0d, t exp %h got %h",
                                     exp_r.hit, hit, exp_r.t, closest_t);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = idle_length();
                out_stall <= stall_left > 0;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_ORG_X: org[0] = val;
            CFG_ORG_Y: org[1] = val;
            CFG_ORG_Z: org[2] = val;
            CFG_DIR_X: dir[0] = val[D_W-1:0];
            CFG_DIR_Y: dir[1] = val[D_W-1:0];
            CFG_DIR_Z: dir[2] = val[D_W-1:0];
            CFG_TOL:   tol = val[TOL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [31:0] tl);
        write_reg(CFG_ORG_X, ox);
        write_reg(CFG_ORG_Y, oy);
        write_reg(CFG_ORG_Z, oz);
        write_reg(CFG_DIR_X, dx);
        write_reg(CFG_DIR_Y, dy);
        write_reg(CFG_DIR_Z, dz);
        write_reg(CFG_TOL, tl);
    endtask

    // hold off until every result is in and the block has drained
    task automatic drain();
        while (pending_tris.size() > 0 || expected_results.size() > 0 || in_valid)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic tri_item_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                           int x2, int y2, int z2, bit last);
        tri_item_t tr;
        tr.v = '{x2, y2, z2, x1, y1, z1, x0, y0, z0};
        tr.v[0] = x0; tr.v[1] = y0; tr.v[2] = z0;
        tr.v[3] = x1; tr.v[4] = y1; tr.v[5] = z1;
        tr.v[6] = x2; tr.v[7] = y2; tr.v[8] = z2;
        tr.last = last;
        return tr;
    endfunction

    // triangle scattered around a point on the current ray, or with fully random vertices
    function automatic tri_item_t random_tri();
        tri_item_t tr;
        longint tt, p [3];
        int r, spread;
        r = $urandom_range(0, 99);
        tt = longint'($urandom_range(0, 1 << 26)) - 4096;
        spread = 1 << $urandom_range(4, 24);
        for (int i = 0; i < 3; i++)
            p[i] = longint'($signed(org[i])) + ((longint'($signed(dir[i])) * tt) >>> 16);
        for (int k = 0; k < 9; k++)
        begin
            if (r < 15)
                tr.v[k] = $urandom;
            else
                tr.v[k] = 32'(p[k % 3] + longint'($urandom_range(0, 2 * spread)) - spread);
        end
        // collapsed vertices give degenerate triangles
        if (r >= 15 && r < 23)
        begin
            if ($urandom_range(0, 1))
                tr.v[5:3] = tr.v[2:0];
            else
                tr.v[5:3] = tr.v[8:6];
        end
        if (r >= 23 && r < 27)
            tr.v[8:6] = tr.v[2:0];
        tr.last = ($urandom_range(0, 4) == 0);
        return tr;
    endfunction

    initial
    begin
        int unit;
        org = '{32'd0, 32'd0, 32'd0};
        dir = '{18'(DIR_X_RESET), 18'd0, 18'd0};
        tol = TOL_W'(TOL_RESET);
        best_t = T_MAX;
        any_hit = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        unit = 1 << FRAC_BITS;
        // directed: reset ray along +x from the origin
        pending_tris.push_back(make_tri(5*unit, -unit, -unit, 5*unit, 2*unit, -unit,
                                        5*unit, -unit, 2*unit, 1'b1));
        pending_tris.push_back(make_tri(unit, 0, 0, unit, 0, 0, unit, 0, 0, 1'b1));
        pending_tris.push_back(make_tri(-5*unit, -unit, -unit, -5*unit, 2*unit, -unit,
                                        -5*unit, -unit, 2*unit, 1'b1));
        pending_tris.push_back(make_tri(5*unit, 3*unit, 3*unit, 5*unit, 6*unit, 3*unit,
                                        5*unit, 3*unit, 6*unit, 1'b1));
        // far distance near the top of the range, then equal and smaller hits within one mesh
        pending_tris.push_back(make_tri(32'h7FFF0000, -unit, -unit, 32'h7FFF0000, 2*unit,
                                        -unit, 32'h7FFF0000, -unit, 2*unit, 1'b0));
        pending_tris.push_back(make_tri(7*unit, -unit, -unit, 7*unit, 2*unit, -unit,
                                        7*unit, -unit, 2*unit, 1'b0));
        pending_tris.push_back(make_tri(7*unit, -unit, -unit, 7*unit, 2*unit, -unit,
                                        7*unit, -unit, 2*unit, 1'b0));
        pending_tris.push_back(make_tri(3*unit, -unit, -unit, 3*unit, 2*unit, -unit,
                                        3*unit, -unit, 2*unit, 1'b1));
        // edge exactly on the ray, tiny distance, vertex extremes
        pending_tris.push_back(make_tri(4*unit, 0, -unit, 4*unit, 2*unit, -unit,
                                        4*unit, 0, unit, 1'b1));
        pending_tris.push_back(make_tri(0, -unit, -unit, 1, 2*unit, -unit,
                                        0, -unit, 2*unit, 1'b1));
        pending_tris.push_back(make_tri(32'h80000000, 32'h80000000, 32'h80000000,
                                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1));
        pending_tris.push_back(make_tri(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                        32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1));
        pending_tris.push_back(make_tri(unit, unit, unit, 2*unit, unit, unit,
                                        unit, 2*unit, unit, 1'b1));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: ;
                1: set_ray($urandom_range(0, 1 << 20), 3*unit, -2*unit,
                           0, unit, 0, 0);
                2: set_ray(-$urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21), 0,
                           -unit, 0, 0, unit);
                3: set_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                           $urandom, $urandom, $urandom, 32'h1FFFF);
                4: set_ray($urandom, $urandom, $urandom, 46341, 0, -46341, TOL_RESET);
                default: set_ray($urandom_range(0, 1 << 18), -unit, unit,
                                 0, 0, 32'h20000, $urandom_range(0, 1 << 17));
            endcase
            no_idle = (ph == 4);
            for (int n = 0; n < 270; n++)
                pending_tris.push_back(random_tri());
            // close the mesh so every phase ends idle
            pending_tris[pending_tris.size() - 1].last = 1'b1;
            drain();
        end

        $display("%0d triangles over %0d meshes (%0d hit), reset ray plus 5 other settings",
                 tris_sent, meshes_seen, hits_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("** ray_triangle_closest_hit: PASSED **");
        else
            $display("** ray_triangle_closest_hit: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("** ray_triangle_closest_hit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rtc_pkg.sv
hw/rtl/rtc_mac.sv
hw/rtl/rtc_dp.sv
hw/rtl/rtc_ctrl.sv
hw/rtl/ray_triangle_closest_hit.sv
verif/tb_ray_triangle_closest_hit.sv
